// File: sv/pointwise_abs_and_gradient_macros.svh
// Assertion helpers for the checker file of this block.
`ifndef POINTWISE_ABS_AND_GRADIENT_MACROS_SVH
`define POINTWISE_ABS_AND_GRADIENT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define PAG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define PAG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked through reset.
`define PAG_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/pag_pkg.sv
package pag_pkg;

  localparam int DATA_W = 32;
  localparam int WIDE_W = 2 * DATA_W;

  localparam logic [2:0] OP_ABS_RE  = 3'd0;
  localparam logic [2:0] OP_ABS_CX  = 3'd1;
  localparam logic [2:0] OP_GRAD_RR = 3'd2;
  localparam logic [2:0] OP_GRAD_RC = 3'd3;
  localparam logic [2:0] OP_GRAD_CR = 3'd4;
  localparam logic [2:0] OP_GRAD_CC = 3'd5;

  localparam logic signed [DATA_W-1:0] POS_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic signed [DATA_W-1:0] NEG_LIM = {1'b1, {(DATA_W-1){1'b0}}};

  // How the back end finishes a transaction.
  typedef enum logic [1:0] {
    KIND_DIRECT,
    KIND_MAG,
    KIND_GRAD
  } pag_kind_t;

  typedef struct packed {
    logic [2:0]               op;
    logic signed [DATA_W-1:0] x_re;
    logic signed [DATA_W-1:0] x_im;
    logic signed [DATA_W-1:0] g_re;
    logic signed [DATA_W-1:0] g_im;
  } pag_in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] y_re;
    logic signed [DATA_W-1:0] y_im;
    logic                     saturated;
  } pag_out_t;

  localparam pag_out_t RES_ZERO = '{y_re: '0, y_im: '0, saturated: 1'b0};

  // Classified transaction handed from the front end to the back end.
  typedef struct packed {
    pag_kind_t                kind;
    logic signed [DATA_W-1:0] x_re;
    logic signed [DATA_W-1:0] x_im;
    logic signed [DATA_W-1:0] g_re;
    logic signed [DATA_W-1:0] g_im;
    pag_out_t                 res;
  } pag_job_t;

endpackage

// File: sv/pag_front.sv
module pag_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pag_pkg::pag_in_t  in_data,
  output logic              job_valid,
  input  logic              job_ready,
  output pag_pkg::pag_job_t job
);
  import pag_pkg::*;

  // Returns {saturated, -v}, clamping the negation of the most negative value.
  function automatic logic [DATA_W:0] neg_sat(input logic signed [DATA_W-1:0] v);
    logic [DATA_W:0] r;
    if (v == NEG_LIM) begin
      r = {1'b1, POS_MAX};
    end else begin
      r = {1'b0, -v};
    end
    return r;
  endfunction

  logic            valid_r;
  pag_job_t        job_r;
  pag_job_t        job_nxt;
  logic [DATA_W:0] nxr;
  logic [DATA_W:0] ngr;
  logic [DATA_W:0] ngi;
  logic            x_pos;
  logic            x_neg;
  logic            z_zero;

  assign nxr    = neg_sat(in_data.x_re);
  assign ngr    = neg_sat(in_data.g_re);
  assign ngi    = neg_sat(in_data.g_im);
  assign x_neg  = in_data.x_re[DATA_W-1];
  assign x_pos  = !x_neg && (in_data.x_re != '0);
  assign z_zero = (in_data.x_re == '0) && (in_data.x_im == '0);

  // Real modes and complex gradients at zero are finished here; other complex modes are tagged for the back end.
  always_comb begin
    job_nxt      = '0;
    job_nxt.kind = KIND_DIRECT;
    job_nxt.x_re = in_data.x_re;
    job_nxt.x_im = in_data.x_im;
    job_nxt.g_re = in_data.g_re;
    job_nxt.g_im = in_data.g_im;
    job_nxt.res  = RES_ZERO;
    case (in_data.op)
      OP_ABS_RE: begin
        if (x_neg) begin
          job_nxt.res.y_re      = nxr[DATA_W-1:0];
          job_nxt.res.saturated = nxr[DATA_W];
        end else begin
          job_nxt.res.y_re = in_data.x_re;
        end
      end
      OP_ABS_CX: job_nxt.kind = KIND_MAG;
      OP_GRAD_RR: begin
        if (x_pos) begin
          job_nxt.res.y_re = in_data.g_re;
        end else if (x_neg) begin
          job_nxt.res.y_re      = ngr[DATA_W-1:0];
          job_nxt.res.saturated = ngr[DATA_W];
        end
      end
      OP_GRAD_RC: begin
        if (x_pos) begin
          job_nxt.res.y_re = in_data.g_re;
          job_nxt.res.y_im = in_data.g_im;
        end else if (x_neg) begin
          job_nxt.res.y_re      = ngr[DATA_W-1:0];
          job_nxt.res.y_im      = ngi[DATA_W-1:0];
          job_nxt.res.saturated = ngr[DATA_W] | ngi[DATA_W];
        end
      end
      OP_GRAD_CR: begin
        // A real gradient is a complex one with a zero imaginary part.
        job_nxt.g_im = '0;
        if (!z_zero) job_nxt.kind = KIND_GRAD;
      end
      OP_GRAD_CC: begin
        if (!z_zero) job_nxt.kind = KIND_GRAD;
      end
      default: job_nxt.kind = KIND_DIRECT;
    endcase
  end

  assign in_ready  = !valid_r || job_ready;
  assign job_valid = valid_r;
  assign job       = job_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      job_r <= job_nxt;
    end
  end

endmodule

// File: sv/pag_fifo.sv
module pag_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         wr_valid,
  output logic         wr_ready,
  input  logic [W-1:0] wr_data,
  output logic         rd_valid,
  input  logic         rd_ready,
  output logic [W-1:0] rd_data
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          push;
  logic          pop;

  assign wr_ready = cnt_r != CW'(DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem_r[rd_ptr_r];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(push) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// File: sv/pag_isqrt.sv
module pag_isqrt #(
  parameter int RW     = 32,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [2*RW-1:0]   in_rad,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [RW-1:0]     out_root,
  output logic [SIDE_W-1:0] out_side
);
  // Digit-by-digit floor square root, one result bit per stage.
  localparam int REM_W = RW + 2;

  logic              vld_r  [RW];
  logic [RW-1:0]     root_r [RW];
  logic [SIDE_W-1:0] side_r [RW];
  logic [REM_W-1:0]  rem_r  [RW-1];
  logic [2*RW-1:0]   rad_r  [RW-1];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    logic              vld_in;
    logic [REM_W-1:0]  rem_in;
    logic [RW-1:0]     root_in;
    logic [2*RW-1:0]   rad_in;
    logic [SIDE_W-1:0] side_in;
    logic [REM_W+1:0]  t;
    logic [REM_W+1:0]  trial;
    logic              ge;

    if (k == 0) begin : g_first
      assign vld_in  = in_valid;
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = in_rad;
      assign side_in = in_side;
    end else begin : g_next
      assign vld_in  = vld_r[k-1];
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
      assign rad_in  = rad_r[k-1];
      assign side_in = side_r[k-1];
    end

    assign t     = {rem_in, rad_in[2*RW-1 -: 2]};
    assign trial = {2'b00, root_in, 2'b01};
    assign ge    = t >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        root_r[k] <= {root_in[RW-2:0], ge};
        side_r[k] <= side_in;
      end
    end

    if (k < RW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_r[k] <= REM_W'(ge ? t - trial : t);
          rad_r[k] <= {rad_in[2*RW-3:0], 2'b00};
        end
      end
    end
  end

  assign out_valid = vld_r[RW-1];
  assign out_root  = root_r[RW-1];
  assign out_side  = side_r[RW-1];

endmodule

// File: sv/pag_div.sv
module pag_div #(
  parameter int DW     = 32,
  parameter int QW     = 32,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [DW-1:0]     in_dvs,
  input  logic [DW-1:0]     in_hi_a,
  input  logic [QW-1:0]     in_lo_a,
  input  logic [DW-1:0]     in_hi_b,
  input  logic [QW-1:0]     in_lo_b,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_valid,
  output logic [QW-1:0]     out_quo_a,
  output logic [QW-1:0]     out_quo_b,
  output logic [SIDE_W-1:0] out_side
);
  // Two restoring dividers sharing one divisor, one quotient bit per stage.
  // The high part of each dividend must already be below the divisor.

  function automatic logic [DW+QW-1:0] div_step(input logic [DW-1:0] rem,
                                               input logic [QW-1:0] acc,
                                               input logic [DW-1:0] dvs);
    logic [DW:0] t;
    logic        ge;
    t  = {rem, acc[QW-1]};
    ge = t >= {1'b0, dvs};
    return {DW'(ge ? t - {1'b0, dvs} : t), acc[QW-2:0], ge};
  endfunction

  logic              vld_r   [QW];
  logic [QW-1:0]     acc_a_r [QW];
  logic [QW-1:0]     acc_b_r [QW];
  logic [SIDE_W-1:0] side_r  [QW];
  logic [DW-1:0]     rem_a_r [QW-1];
  logic [DW-1:0]     rem_b_r [QW-1];
  logic [DW-1:0]     dvs_r   [QW-1];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic              vld_in;
    logic [DW-1:0]     dvs_in;
    logic [DW-1:0]     rem_a_in;
    logic [DW-1:0]     rem_b_in;
    logic [QW-1:0]     acc_a_in;
    logic [QW-1:0]     acc_b_in;
    logic [SIDE_W-1:0] side_in;
    logic [DW+QW-1:0]  step_a;
    logic [DW+QW-1:0]  step_b;

    if (k == 0) begin : g_first
      assign vld_in   = in_valid;
      assign dvs_in   = in_dvs;
      assign rem_a_in = in_hi_a;
      assign rem_b_in = in_hi_b;
      assign acc_a_in = in_lo_a;
      assign acc_b_in = in_lo_b;
      assign side_in  = in_side;
    end else begin : g_next
      assign vld_in   = vld_r[k-1];
      assign dvs_in   = dvs_r[k-1];
      assign rem_a_in = rem_a_r[k-1];
      assign rem_b_in = rem_b_r[k-1];
      assign acc_a_in = acc_a_r[k-1];
      assign acc_b_in = acc_b_r[k-1];
      assign side_in  = side_r[k-1];
    end

    assign step_a = div_step(rem_a_in, acc_a_in, dvs_in);
    assign step_b = div_step(rem_b_in, acc_b_in, dvs_in);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (adv) begin
        vld_r[k] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        acc_a_r[k] <= step_a[QW-1:0];
        acc_b_r[k] <= step_b[QW-1:0];
        side_r[k]  <= side_in;
      end
    end

    if (k < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_a_r[k] <= step_a[DW+QW-1:QW];
          rem_b_r[k] <= step_b[DW+QW-1:QW];
          dvs_r[k]   <= dvs_in;
        end
      end
    end
  end

  assign out_valid = vld_r[QW-1];
  assign out_quo_a = acc_a_r[QW-1];
  assign out_quo_b = acc_b_r[QW-1];
  assign out_side  = side_r[QW-1];

endmodule

// File: sv/pag_back.sv
module pag_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  output logic              job_ready,
  input  pag_pkg::pag_job_t job,
  output logic              out_valid,
  input  logic              out_ready,
  output pag_pkg::pag_out_t out_data
);
  import pag_pkg::*;

  typedef struct packed {
    pag_kind_t         kind;
    pag_out_t          res;
    logic              neg_a;
    logic [WIDE_W-1:0] mag_a;
    logic              neg_b;
    logic [WIDE_W-1:0] mag_b;
  } sq_side_t;

  typedef struct packed {
    logic     is_grad;
    pag_out_t res;
    logic     neg_a;
    logic     neg_b;
    logic     ovf_a;
    logic     ovf_b;
  } dv_side_t;

  // Clamps a sign and quotient to the signed range; returns {saturated, value}.
  function automatic logic [DATA_W:0] sat_quo(input logic neg, input logic ovf,
                                              input logic [DATA_W-1:0] q);
    logic [DATA_W:0] r;
    if (ovf) begin
      r = {1'b1, neg ? NEG_LIM : POS_MAX};
    end else if (!neg) begin
      r = q[DATA_W-1] ? {1'b1, POS_MAX} : {1'b0, q};
    end else if (q[DATA_W-1] && (q[DATA_W-2:0] != '0)) begin
      r = {1'b1, NEG_LIM};
    end else begin
      r = {1'b0, -q};
    end
    return r;
  endfunction

  logic adv;

  // Stage 1: products.
  logic                     s1_v_r;
  pag_kind_t                s1_kind_r;
  pag_out_t                 s1_res_r;
  logic signed [WIDE_W-1:0] s1_sq_re_r, s1_sq_im_r;
  logic signed [WIDE_W-1:0] s1_p_rr_r, s1_p_ii_r, s1_p_ri_r, s1_p_ir_r;
  logic signed [WIDE_W-1:0] sq_re_nxt, sq_im_nxt;
  logic signed [WIDE_W-1:0] p_rr_nxt, p_ii_nxt, p_ri_nxt, p_ir_nxt;

  // Stage 2: sums.
  logic                     s2_v_r;
  pag_kind_t                s2_kind_r;
  pag_out_t                 s2_res_r;
  logic [WIDE_W-1:0]        s2_ssq_r;
  logic signed [WIDE_W:0]   s2_num_re_r, s2_num_im_r;

  sq_side_t                 sq_in;
  sq_side_t                 sq_out;
  logic                     sq_valid;
  logic [DATA_W-1:0]        sq_root;

  // Divider setup stage.
  logic                     d0_v_r;
  dv_side_t                 d0_side_r;
  dv_side_t                 d0_side_nxt;
  logic [DATA_W-1:0]        d0_dvs_r;
  logic [DATA_W-1:0]        d0_hi_a_r, d0_lo_a_r, d0_hi_b_r, d0_lo_b_r;
  pag_out_t                 mag_res;

  logic                     dv_valid;
  logic [DATA_W-1:0]        quo_a, quo_b;
  dv_side_t                 dv_out;
  logic [DATA_W:0]          pk_a, pk_b;

  logic                     out_valid_r;
  pag_out_t                 out_data_r;
  pag_out_t                 out_data_nxt;

  assign adv       = !out_valid_r || out_ready;
  assign job_ready = adv;

  assign sq_re_nxt = job.x_re * job.x_re;
  assign sq_im_nxt = job.x_im * job.x_im;
  assign p_rr_nxt  = job.g_re * job.x_re;
  assign p_ii_nxt  = job.g_im * job.x_im;
  assign p_ri_nxt  = job.g_re * job.x_im;
  assign p_ir_nxt  = job.g_im * job.x_re;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      d0_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= job_valid;
      s2_v_r <= s1_v_r;
      d0_v_r <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_kind_r   <= job.kind;
      s1_res_r    <= job.res;
      s1_sq_re_r  <= sq_re_nxt;
      s1_sq_im_r  <= sq_im_nxt;
      s1_p_rr_r   <= p_rr_nxt;
      s1_p_ii_r   <= p_ii_nxt;
      s1_p_ri_r   <= p_ri_nxt;
      s1_p_ir_r   <= p_ir_nxt;
      s2_kind_r   <= s1_kind_r;
      s2_res_r    <= s1_res_r;
      // Squares are never negative and their sum is at most 2^63, which
      // still fits in 64 unsigned bits.
      s2_ssq_r    <= s1_sq_re_r + s1_sq_im_r;
      s2_num_re_r <= {s1_p_rr_r[WIDE_W-1], s1_p_rr_r} - {s1_p_ii_r[WIDE_W-1], s1_p_ii_r};
      s2_num_im_r <= {s1_p_ri_r[WIDE_W-1], s1_p_ri_r} + {s1_p_ir_r[WIDE_W-1], s1_p_ir_r};
      d0_side_r   <= d0_side_nxt;
      d0_dvs_r    <= sq_root;
      d0_hi_a_r   <= sq_out.mag_a[WIDE_W-1:DATA_W];
      d0_lo_a_r   <= sq_out.mag_a[DATA_W-1:0];
      d0_hi_b_r   <= sq_out.mag_b[WIDE_W-1:DATA_W];
      d0_lo_b_r   <= sq_out.mag_b[DATA_W-1:0];
    end
  end

  // Numerators go through the root pipeline as sign and magnitude.
  always_comb begin
    sq_in.kind  = s2_kind_r;
    sq_in.res   = s2_res_r;
    sq_in.neg_a = s2_num_re_r[WIDE_W];
    sq_in.mag_a = s2_num_re_r[WIDE_W] ? WIDE_W'(-s2_num_re_r) : s2_num_re_r[WIDE_W-1:0];
    sq_in.neg_b = s2_num_im_r[WIDE_W];
    sq_in.mag_b = s2_num_im_r[WIDE_W] ? WIDE_W'(-s2_num_im_r) : s2_num_im_r[WIDE_W-1:0];
  end

  pag_isqrt #(
    .RW     (DATA_W),
    .SIDE_W ($bits(sq_side_t))
  ) u_isqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (s2_v_r),
    .in_rad    (s2_ssq_r),
    .in_side   (sq_in),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_side  (sq_out)
  );

  // The magnitude result is final here; a quotient of 2^32 or more overflows.
  always_comb begin
    mag_res.y_re      = sq_root[DATA_W-1] ? POS_MAX : sq_root;
    mag_res.y_im      = '0;
    mag_res.saturated = sq_root[DATA_W-1];
    d0_side_nxt.is_grad = sq_out.kind == KIND_GRAD;
    d0_side_nxt.res     = (sq_out.kind == KIND_MAG) ? mag_res : sq_out.res;
    d0_side_nxt.neg_a   = sq_out.neg_a;
    d0_side_nxt.neg_b   = sq_out.neg_b;
    d0_side_nxt.ovf_a   = sq_out.mag_a[WIDE_W-1:DATA_W] >= sq_root;
    d0_side_nxt.ovf_b   = sq_out.mag_b[WIDE_W-1:DATA_W] >= sq_root;
  end

  pag_div #(
    .DW     (DATA_W),
    .QW     (DATA_W),
    .SIDE_W ($bits(dv_side_t))
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .in_valid  (d0_v_r),
    .in_dvs    (d0_dvs_r),
    .in_hi_a   (d0_hi_a_r),
    .in_lo_a   (d0_lo_a_r),
    .in_hi_b   (d0_hi_b_r),
    .in_lo_b   (d0_lo_b_r),
    .in_side   (d0_side_r),
    .out_valid (dv_valid),
    .out_quo_a (quo_a),
    .out_quo_b (quo_b),
    .out_side  (dv_out)
  );

  assign pk_a = sat_quo(dv_out.neg_a, dv_out.ovf_a, quo_a);
  assign pk_b = sat_quo(dv_out.neg_b, dv_out.ovf_b, quo_b);

  always_comb begin
    if (dv_out.is_grad) begin
      out_data_nxt.y_re      = pk_a[DATA_W-1:0];
      out_data_nxt.y_im      = pk_b[DATA_W-1:0];
      out_data_nxt.saturated = pk_a[DATA_W] | pk_b[DATA_W];
    end else begin
      out_data_nxt = dv_out.res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= dv_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: sv/pointwise_abs_and_gradient.sv
// Elementwise absolute value and its backward gradient on signed Q16.16
// values: one transaction in, one result transaction out, in order. The block
// accepts one transaction per clock and delivers one per clock as long as the
// result side keeps taking them. A result passes through the input register,
// the queue, the multiply stage and the add stage, the 32-stage square-root
// pipeline with one result bit per stage, the divider setup stage, the
// 32-stage divider with one quotient bit per stage and the output register.
// A stalled output freezes the back end, while the front end keeps filling
// the queue until it is full.
module pointwise_abs_and_gradient #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pag_pkg::pag_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pag_pkg::pag_out_t out_data
);
  import pag_pkg::*;

  // The front end registers each transaction and finishes the real modes
  // (absolute value and sign pass-through of the gradient) right away. The
  // complex modes are tagged for the back end; a complex gradient with a zero
  // input is finished here as zero.
  logic     fr_valid;
  logic     fr_ready;
  pag_job_t fr_job;

  // Queue between the two halves so that each can stall on its own.
  logic     bk_valid;
  logic     bk_ready;
  pag_job_t bk_job;

  pag_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .job_valid (fr_valid),
    .job_ready (fr_ready),
    .job       (fr_job)
  );

  pag_fifo #(
    .W     ($bits(pag_job_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (fr_valid),
    .wr_ready (fr_ready),
    .wr_data  (fr_job),
    .rd_valid (bk_valid),
    .rd_ready (bk_ready),
    .rd_data  (bk_job)
  );

  // The back end forms the exact products, the floor magnitude of the complex
  // input and the truncating quotients, then saturates each part. Every
  // transaction walks the whole pipeline so that results keep their order.
  pag_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (bk_valid),
    .job_ready (bk_ready),
    .job       (bk_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: sv/pag_checker.sv
module pag_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              out_valid,
  input logic              out_ready,
  input pag_pkg::pag_out_t out_data
);
  import pag_pkg::*;
`include "pointwise_abs_and_gradient_macros.svh"

  // A clamped result always shows a limit value in one of its parts.
  `PAG_ASSERT_NOW(a_sat_limit, out_valid && out_data.saturated, (out_data.y_re == POS_MAX) || (out_data.y_re == NEG_LIM) || (out_data.y_im == POS_MAX) || (out_data.y_im == NEG_LIM), "saturated result without a limit value")
  // Nothing is offered in the cycle after reset.
  `PAG_ASSERT_ALWAYS(a_reset_idle, !rst_n, !out_valid, "result offered right after reset")
  `PAG_ASSERT_NEXT(a_hold_valid, out_valid && !out_ready, out_valid, "result withdrawn before transaction")
  `PAG_ASSERT_NEXT(a_hold_data, out_valid && !out_ready, $stable(out_data), "stalled result changed")

endmodule

bind pointwise_abs_and_gradient pag_checker u_pag_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
